FILE: design/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEQ_DEPTH      = 64;
	localparam int DEQ_DATA_WIDTH = 32;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [2:0] MODE_PEEK_BACK  = 3'd5;
	localparam logic [2:0] MODE_CLEAR      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// broadcast to every cell; already qualified by full/empty
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic clear;
	} cell_cmd_t;

endpackage

FILE: design/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell #(
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  deq_pkg::cell_cmd_t    cmd,
	input  logic [DATA_WIDTH-1:0] push_word,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  right_valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  valid,
	output logic                  last
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  valid_q;
	logic                  first_free;

	// first empty slot after the occupied run
	assign first_free = !valid_q && left_valid;
	assign last       = valid_q && !right_valid;

	always_ff @(posedge clk) begin
		priority if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (cmd.push_back && first_free) begin
			data_q <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (cmd.clear) begin
				valid_q <= 1'b0;
			end else if (cmd.push_front) begin
				valid_q <= left_valid;
			end else if (cmd.pop_front) begin
				valid_q <= right_valid;
			end else if (cmd.push_back && first_free) begin
				valid_q <= 1'b1;
			end else if (cmd.pop_back && last) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

FILE: design/double_ended_queue_core.sv
`timescale 1ns / 1ps
// The done strobe with the result is registered and comes in the cycle after the start transfer.
// Throughput: one request per cycle; busy stays low.
// Elements sit in a row of cells, front at cell 0; pushes and pops at the front
// shift the whole row by one place, the back is found by each cell's valid bit.
// Reset clears the cell valid bits, the count and the strobe; stored words are not reset.
// The receiver cannot stall: done lasts one cycle.

module double_ended_queue_core #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   mode,
	input  logic signed [DATA_WIDTH-1:0] push_word,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] read_word,
	output logic [$clog2(DEPTH+1)-1:0]   occupancy,
	output logic [1:0]                   status
);
	import deq_pkg::*;

	localparam int CountW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
	logic                  cell_valid [DEPTH];
	logic                  cell_last  [DEPTH];

	logic [CountW-1:0]     count_q;
	logic [CountW-1:0]     count_nx;
	logic                  full;
	logic                  empty;
	logic                  accept;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] back_word;
	logic [DATA_WIDTH-1:0] rd_nx;
	logic [1:0]            st_nx;

	logic                  done_q;
	logic [DATA_WIDTH-1:0] read_word_q;
	logic [CountW-1:0]     occupancy_q;
	logic [1:0]            status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CountW'(DEPTH));
	assign empty  = (count_q == '0);

	// one-hot pick of the back element
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
		end
	end

	always_comb begin
		cmd      = '0;
		rd_nx    = '0;
		st_nx    = ST_OK;
		count_nx = count_q;
		unique case (mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					st_nx = ST_FULL;
				end else begin
					cmd.push_front = accept && (mode == MODE_PUSH_FRONT);
					cmd.push_back  = accept && (mode == MODE_PUSH_BACK);
					count_nx       = count_q + CountW'(1);
				end
			end
			MODE_POP_FRONT, MODE_PEEK_FRONT: begin
				if (empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rd_nx = cell_data[0];
					if (mode == MODE_POP_FRONT) begin
						cmd.pop_front = accept;
						count_nx      = count_q - CountW'(1);
					end
				end
			end
			MODE_POP_BACK, MODE_PEEK_BACK: begin
				if (empty) begin
					st_nx = ST_EMPTY;
				end else begin
					rd_nx = back_word;
					if (mode == MODE_POP_BACK) begin
						cmd.pop_back = accept;
						count_nx     = count_q - CountW'(1);
					end
				end
			end
			MODE_CLEAR: begin
				cmd.clear = accept;
				count_nx  = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] l_data;
		logic                  l_valid;
		logic [DATA_WIDTH-1:0] r_data;
		logic                  r_valid;

		if (i == 0) begin : g_head
			// the head cell's left neighbour is the incoming word
			assign l_data  = push_word;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end

		deq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_word  (push_word),
			.left_data  (l_data),
			.left_valid (l_valid),
			.right_data (r_data),
			.right_valid(r_valid),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.last       (cell_last[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_word_q <= rd_nx;
			occupancy_q <= count_nx;
			status_q    <= st_nx;
		end
	end

	assign done      = done_q;
	assign read_word = read_word_q;
	assign occupancy = occupancy_q;
	assign status    = status_q;

endmodule

FILE: design/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [2:0]                   mode,
	input logic                         done,
	input logic signed [DATA_WIDTH-1:0] read_word,
	input logic [$clog2(DEPTH+1)-1:0]   occupancy,
	input logic [1:0]                   status
);
	import deq_pkg::*;

	localparam int CountW = $clog2(DEPTH + 1);

	// every transfer gives exactly one result, in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result after request transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without request");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == CountW'(DEPTH)))
		else $error("full status with room left");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (occupancy == '0 && read_word == '0))
		else $error("empty status with data");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_CLEAR) |=> (occupancy == '0 && status == ST_OK))
		else $error("clear left elements");

endmodule

bind double_ended_queue_core deq_checker #(
	.DEPTH     (DEPTH),
	.DATA_WIDTH(DATA_WIDTH)
) u_deq_checker (.*);
